/* rtl/core/thp_pkg.sv */
package thp_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_pa;
      logic [16:0]        humidity_q10;
   } rsp_type;

   typedef struct packed {
      logic [47:0] tcal;
      logic [63:0] pcal_lo;
      logic [63:0] pcal_hi;
      logic [15:0] pcal_top;
      logic [63:0] hcal;
   } cal_type;

   localparam logic [2:0] REG_TCAL    = 3'd0;
   localparam logic [2:0] REG_PCAL_LO = 3'd1;
   localparam logic [2:0] REG_PCAL_HI = 3'd2;
   localparam logic [2:0] REG_PCAL_TP = 3'd3;
   localparam logic [2:0] REG_HCAL    = 3'd4;

   localparam logic [31:0] HUM_MAX = 32'd419430400;

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      sra = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] v);
      sx12 = {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      sx8 = {{24{v[7]}}, v};
   endfunction

endpackage

/* rtl/core/thp_csr.sv */
module thp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [5:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output thp_pkg::cal_type  cal
);

   thp_pkg::cal_type cal_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx = csr_paddr[5:3];
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign cal = cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (wr) begin
         case (idx)
            thp_pkg::REG_TCAL:    cal_ff.tcal     <= csr_pwdata[47:0];
            thp_pkg::REG_PCAL_LO: cal_ff.pcal_lo  <= csr_pwdata;
            thp_pkg::REG_PCAL_HI: cal_ff.pcal_hi  <= csr_pwdata;
            thp_pkg::REG_PCAL_TP: cal_ff.pcal_top <= csr_pwdata[15:0];
            thp_pkg::REG_HCAL:    cal_ff.hcal     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         thp_pkg::REG_TCAL:    csr_prdata = {16'd0, cal_ff.tcal};
         thp_pkg::REG_PCAL_LO: csr_prdata = cal_ff.pcal_lo;
         thp_pkg::REG_PCAL_HI: csr_prdata = cal_ff.pcal_hi;
         thp_pkg::REG_PCAL_TP: csr_prdata = {48'd0, cal_ff.pcal_top};
         thp_pkg::REG_HCAL:    csr_prdata = cal_ff.hcal;
         default:              csr_prdata = '0;
      endcase
   end

endmodule

/* rtl/core/thp_div.sv */
module thp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   input  logic        in_big,
   output logic        out_valid,
   output logic [31:0] out_quot
);

   logic [31:0] rem_ff [33];
   logic [31:0] quo_ff [33];
   logic [31:0] den_ff [33];
   logic        big_ff [33];
   logic [32:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[31:0], in_valid};
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      quo_ff[0] <= in_num;
      den_ff[0] <= in_den;
      big_ff[0] <= in_big;
      for (int i = 0; i < 32; i++) begin
         logic [32:0] t;
         t = {rem_ff[i], quo_ff[i][31]};
         if (t >= {1'b0, den_ff[i]}) begin
            rem_ff[i+1] <= 32'(t - {1'b0, den_ff[i]});
            quo_ff[i+1] <= {quo_ff[i][30:0], 1'b1};
         end else begin
            rem_ff[i+1] <= t[31:0];
            quo_ff[i+1] <= {quo_ff[i][30:0], 1'b0};
         end
         den_ff[i+1] <= den_ff[i];
         big_ff[i+1] <= big_ff[i];
      end
   end

   assign out_valid = vld_ff[32];
   assign out_quot  = big_ff[32] ? {quo_ff[32][30:0], 1'b0} : quo_ff[32];

endmodule

/* rtl/core/thp_datapath.sv */
module thp_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  thp_pkg::req_type in_beat,
   input  thp_pkg::cal_type cal,
   output logic             out_valid,
   output thp_pkg::rsp_type out_beat
);

   localparam int DL = 33;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   assign t1 = {16'd0, cal.tcal[15:0]};
   assign t2 = thp_pkg::sx16(cal.tcal[31:16]);
   assign t3 = thp_pkg::sx16(cal.tcal[47:32]);
   assign p1 = {16'd0, cal.pcal_lo[15:0]};
   assign p2 = thp_pkg::sx16(cal.pcal_lo[31:16]);
   assign p3 = thp_pkg::sx16(cal.pcal_lo[47:32]);
   assign p4 = thp_pkg::sx16(cal.pcal_lo[63:48]);
   assign p5 = thp_pkg::sx16(cal.pcal_hi[15:0]);
   assign p6 = thp_pkg::sx16(cal.pcal_hi[31:16]);
   assign p7 = thp_pkg::sx16(cal.pcal_hi[47:32]);
   assign p8 = thp_pkg::sx16(cal.pcal_hi[63:48]);
   assign p9 = thp_pkg::sx16(cal.pcal_top);
   assign h1 = {24'd0, cal.hcal[7:0]};
   assign h2 = thp_pkg::sx16(cal.hcal[23:8]);
   assign h3 = {24'd0, cal.hcal[31:24]};
   assign h4 = thp_pkg::sx12(cal.hcal[43:32]);
   assign h5 = thp_pkg::sx12(cal.hcal[55:44]);
   assign h6 = thp_pkg::sx8(cal.hcal[63:56]);

   // temperature stages
   logic [9:0]  v_ff;
   logic [19:0] rp_ff [7];
   logic [15:0] rh_ff [5];
   logic [31:0] fd_ff [7];
   logic [31:0] ta_ff, td_ff, ta2_ff, tb_ff, tb2_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[8:0], in_valid};
   end

   always_ff @(posedge clock) begin
      ta_ff    <= thp_pkg::sra({12'd0, in_beat.raw_temperature}, 3) - (t1 << 1);
      td_ff    <= thp_pkg::sra({12'd0, in_beat.raw_temperature}, 4) - t1;
      rp_ff[0] <= in_beat.raw_pressure;
      rh_ff[0] <= in_beat.raw_humidity;
      ta2_ff   <= thp_pkg::sra(32'(ta_ff * t2), 11);
      tb_ff    <= thp_pkg::sra(32'(td_ff * td_ff), 12);
      tb2_ff   <= thp_pkg::sra(32'(tb_ff * t3), 14) + ta2_ff;
      fd_ff[0] <= tb2_ff;
      for (int i = 1; i < 7; i++) begin
         rp_ff[i] <= rp_ff[i-1];
         fd_ff[i] <= fd_ff[i-1];
      end
      for (int i = 1; i < 5; i++) begin
         rh_ff[i] <= rh_ff[i-1];
      end
   end

   // pressure and humidity front, fine temperature from tb2_ff
   logic [31:0] fine;
   assign fine = tb2_ff;
   logic [31:0] pv1_ff, pq2_ff, hh_ff;
   logic [31:0] pv2a_ff, pv1p5_ff, pq2b_ff, pv1p2_ff;
   logic [31:0] pv2_ff, pa_ff, pb_ff;
   logic [31:0] pv2c_ff, pv1d_ff, pv2d_ff;
   logic [31:0] pn_ff, pden_ff;
   logic        pbig_ff, pvd_ff;

   // humidity regs
   logic [31:0] hx_ff, hm6_ff, hm3_ff, hy1_ff, hy2_ff, hy3_ff, hx2_ff;
   logic [31:0] hp_ff, hr_ff, hr2_ff, hs_ff;

   always_ff @(posedge clock) begin
      // s3
      pv1_ff <= thp_pkg::sra(fine, 1) - 32'd64000;
      hh_ff  <= fine - 32'd76800;
      // s4
      pq2_ff   <= 32'(thp_pkg::sra(pv1_ff, 2) * thp_pkg::sra(pv1_ff, 2));
      pv1p5_ff <= 32'(pv1_ff * p5);
      pv1p2_ff <= thp_pkg::sra(32'(p2 * pv1_ff), 1);
      hx_ff    <= 32'(h5 * hh_ff);
      hm6_ff   <= thp_pkg::sra(32'(hh_ff * h6), 10);
      hm3_ff   <= thp_pkg::sra(32'(hh_ff * h3), 11) + 32'd32768;
      // s5
      pv2a_ff  <= 32'(thp_pkg::sra(pq2_ff, 11) * p6) + (pv1p5_ff << 1);
      pq2b_ff  <= thp_pkg::sra(32'(p3 * thp_pkg::sra(pq2_ff, 13)), 3) + pv1p2_ff;
      hx2_ff   <= thp_pkg::sra(({rh_ff[4], 14'd0}) - (h4 << 20) - hx_ff + 32'd16384, 15);
      hy1_ff   <= thp_pkg::sra(32'(hm6_ff * hm3_ff), 10) + 32'd2097152;
      // s6
      pv2_ff   <= thp_pkg::sra(pv2a_ff, 2) + (p4 << 16);
      pv1d_ff  <= 32'd32768 + thp_pkg::sra(pq2b_ff, 18);
      hy2_ff   <= thp_pkg::sra(32'(hy1_ff * h2) + 32'd8192, 14);
      hy3_ff   <= hx2_ff;
      // s7
      pv2c_ff  <= 32'd1048576 - {12'd0, rp_ff[6]} - thp_pkg::sra(pv2_ff, 12);
      pden_ff  <= thp_pkg::sra(32'(pv1d_ff * p1), 15);
      hp_ff    <= 32'(hy3_ff * hy2_ff);
      // s8
      pn_ff    <= 32'(pv2c_ff * 32'd3125);
      pv2d_ff  <= pden_ff;
      hr_ff    <= hp_ff;
      hr2_ff   <= 32'(thp_pkg::sra(hp_ff, 15) * thp_pkg::sra(hp_ff, 15));
      // s9
      pbig_ff  <= pn_ff[31];
      pvd_ff   <= pv2d_ff != 32'd0;
      pa_ff    <= pn_ff[31] ? pn_ff : (pn_ff << 1);
      pb_ff    <= pv2d_ff;
      hs_ff    <= hr_ff - thp_pkg::sra(32'(thp_pkg::sra(hr2_ff, 7) * h1), 4);
   end

   // divider (den zero handled at output)
   logic        dv;
   logic [31:0] dq;
   thp_div u_div (
      .clock(clock), .reset(reset), .in_valid(v_ff[9]),
      .in_num(pa_ff), .in_den(pb_ff), .in_big(pbig_ff),
      .out_valid(dv), .out_quot(dq)
   );

   localparam int TL = DL;
   logic [31:0] tf_ff [TL];
   logic [31:0] tt_ff [TL];
   logic [31:0] hq_ff [TL];
   logic        nz_ff [TL];

   always_ff @(posedge clock) begin
      tf_ff[0] <= fd_ff[6];
      tt_ff[0] <= thp_pkg::sra(fd_ff[6] * 32'd5 + 32'd128, 8);
      hq_ff[0] <= hs_ff;
      nz_ff[0] <= pvd_ff;
      for (int i = 1; i < TL; i++) begin
         tf_ff[i] <= tf_ff[i-1];
         tt_ff[i] <= tt_ff[i-1];
         hq_ff[i] <= hq_ff[i-1];
         nz_ff[i] <= nz_ff[i-1];
      end
   end

   // post-divide correction stages
   logic        c1v_ff, c2v_ff, c3v_ff;
   logic [31:0] c1p_ff, c1a_ff, c1b_ff, c2p_ff, c2a_ff, c2b_ff, c3p_ff;
   logic [31:0] c1t_ff, c1f_ff, c2t_ff, c2f_ff, c3t_ff, c3f_ff;
   logic [31:0] c1h_ff, c2h_ff, c3h_ff;
   logic        c1z_ff, c2z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1v_ff <= 1'b0;
         c2v_ff <= 1'b0;
         c3v_ff <= 1'b0;
      end else begin
         c1v_ff <= dv;
         c2v_ff <= c1v_ff;
         c3v_ff <= c2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1p_ff <= dq;
      c1a_ff <= 32'({3'd0, dq[31:3]} * {3'd0, dq[31:3]}) >> 13;
      c1b_ff <= 32'({2'd0, dq[31:2]} * p8);
      c1t_ff <= tt_ff[TL-1];
      c1f_ff <= tf_ff[TL-1];
      c1h_ff <= hq_ff[TL-1];
      c1z_ff <= nz_ff[TL-1];
      c2p_ff <= c1p_ff;
      c2a_ff <= thp_pkg::sra(32'(p9 * c1a_ff), 12);
      c2b_ff <= thp_pkg::sra(c1b_ff, 13);
      c2t_ff <= c1t_ff;
      c2f_ff <= c1f_ff;
      c2h_ff <= c1h_ff;
      c2z_ff <= c1z_ff;
      c3p_ff <= c2z_ff ? c2p_ff + thp_pkg::sra(c2a_ff + c2b_ff + p7, 4) : 32'd0;
      c3t_ff <= c2t_ff;
      c3f_ff <= c2f_ff;
      if (c2h_ff[31])           c3h_ff <= '0;
      else if (c2h_ff > thp_pkg::HUM_MAX) c3h_ff <= thp_pkg::HUM_MAX;
      else                      c3h_ff <= c2h_ff;
   end

   assign out_valid                  = c3v_ff;
   assign out_beat.temperature_centi = c3t_ff;
   assign out_beat.fine_temperature  = c3f_ff;
   assign out_beat.pressure_pa       = c3p_ff;
   assign out_beat.humidity_q10      = c3h_ff[28:12];

endmodule

/* rtl/core/thp_sensor_compensation_core.sv */
// channel | ports                  | handshake
// request | req_start, req_beat    | taken when req_start and not req_busy
// result  | rsp_strobe, rsp_beat   | one strobe per beat, no stall
// config  | csr_* apb              | write in access phase, pready tied high
// one beat enters every cycle; pressure passes through a pipelined restoring
// divider between the pressure front end and its correction.
// req_busy is always low. synchronous reset clears all valid bits and
// calibration registers to zero.
module thp_sensor_compensation_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              req_busy,
   input  thp_pkg::req_type  req_beat,
   output logic              rsp_strobe,
   output thp_pkg::rsp_type  rsp_beat,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [5:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   thp_pkg::cal_type cal;

   assign req_busy   = 1'b0;
   assign csr_pready = 1'b1;

   thp_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .cal(cal)
   );

   thp_datapath u_dp (
      .clock(clock), .reset(reset), .in_valid(req_start && !req_busy),
      .in_beat(req_beat), .cal(cal), .out_valid(rsp_strobe), .out_beat(rsp_beat)
   );

endmodule

/* rtl/core/thp_checker.sv */
module thp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_busy,
   input logic             rsp_strobe,
   input thp_pkg::rsp_type rsp_beat,
   input logic             csr_pready
);

   a_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
   a_busy: assert property (@(posedge clock) disable iff (reset) !req_busy)
      else $error("busy high");
   a_hum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_beat.humidity_q10 <= 17'd102400)
      else $error("humidity out of range");
   a_idle: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_strobe)
      else $error("strobe after reset");

endmodule

bind thp_sensor_compensation_core thp_checker u_chk (
   .clock(clock), .reset(reset), .req_busy(req_busy),
   .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat), .csr_pready(csr_pready)
);

/* tb/thp_sensor_compensation_core_test.sv */
`timescale 1ns / 1ps

module thp_sensor_compensation_core_test;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_start = 1'b0;
   logic              req_busy;
   thp_pkg::req_type  req_beat = '0;
   logic              rsp_strobe;
   thp_pkg::rsp_type  rsp_beat;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [5:0]        csr_paddr = '0;
   logic [63:0]       csr_pwdata = '0;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   thp_sensor_compensation_core u_top (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_beat(req_beat),
      .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   thp_pkg::cal_type  cal_shadow = '0;
   thp_pkg::rsp_type  pending_readings[$];
   int        mismatch_count = 0;
   int        beats_sent = 0;
   int        beats_checked = 0;
   int        idle_pct = 0;

   localparam logic [47:0] TCAL_TYP = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] PLO_TYP  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] PHI_TYP  = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] PTOP_TYP = 16'd6000;
   localparam logic [63:0] HCAL_TYP = {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75};

   function automatic thp_pkg::rsp_type compensate(thp_pkg::req_type r,
                                                   thp_pkg::cal_type c);
      thp_pkg::rsp_type o;
      int          rt, rp, rh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      int          h1, h2, h3, h4, h5, h6, a, b, d, fine, v1, v2, q, h, x, y, rr;
      int unsigned pu, div, sq;
      rt = int'(r.raw_temperature);
      rp = int'(r.raw_pressure);
      rh = int'(r.raw_humidity);
      t1 = int'(c.tcal[15:0]);
      t2 = $signed(c.tcal[31:16]);
      t3 = $signed(c.tcal[47:32]);
      p1 = int'(c.pcal_lo[15:0]);
      p2 = $signed(c.pcal_lo[31:16]);
      p3 = $signed(c.pcal_lo[47:32]);
      p4 = $signed(c.pcal_lo[63:48]);
      p5 = $signed(c.pcal_hi[15:0]);
      p6 = $signed(c.pcal_hi[31:16]);
      p7 = $signed(c.pcal_hi[47:32]);
      p8 = $signed(c.pcal_hi[63:48]);
      p9 = $signed(c.pcal_top);
      h1 = int'(c.hcal[7:0]);
      h2 = $signed(c.hcal[23:8]);
      h3 = int'(c.hcal[31:24]);
      h4 = $signed(c.hcal[43:32]);
      h5 = $signed(c.hcal[55:44]);
      h6 = $signed(c.hcal[63:56]);

      a = (((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (rt >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      o.temperature_centi = (fine * 5 + 128) >>> 8;
      o.fine_temperature = fine;

      v1 = (fine >>> 1) - 64000;
      q = v1 >>> 2;
      v2 = ((q * q) >>> 11) * p6;
      v2 = v2 + ((v1 * p5) <<< 1);
      v2 = (v2 >>> 2) + (p4 <<< 16);
      v1 = (((p3 * ((q * q) >>> 13)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
      v1 = ((32768 + v1) * p1) >>> 15;
      if (v1 == 0) begin
         pu = 0;
      end else begin
         div = int'(unsigned'(v1));
         a = (1048576 - rp) - (v2 >>> 12);
         pu = unsigned'(a * 3125);
         if (pu < 32'h8000_0000) pu = (pu << 1) / div;
         else pu = (pu / div) * 2;
         sq = ((pu >> 3) * (pu >> 3)) >> 13;
         a = (p9 * int'(sq)) >>> 12;
         b = (int'(pu >> 2) * p8) >>> 13;
         pu = pu + unsigned'((a + b + p7) >>> 4);
      end
      o.pressure_pa = pu;

      h = fine - 76800;
      x = (((rh <<< 14) - (h4 <<< 20) - h5 * h) + 16384) >>> 15;
      y = ((((((h * h6) >>> 10) * (((h * h3) >>> 11) + 32768)) >>> 10) + 2097152)
           * h2 + 8192) >>> 14;
      h = x * y;
      rr = h >>> 15;
      h = h - ((((rr * rr) >>> 7) * h1) >>> 4);
      if (h < 0) h = 0;
      else if (h > 419430400) h = 419430400;
      o.humidity_q10 = 17'(h >>> 12);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      thp_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected beat", 32'd0, 32'd0);
         end else begin
            e = pending_readings.pop_front();
            beats_checked++;
            if (rsp_beat.temperature_centi !== e.temperature_centi)
               report_mismatch("temperature_centi", rsp_beat.temperature_centi,
                               e.temperature_centi);
            if (rsp_beat.fine_temperature !== e.fine_temperature)
               report_mismatch("fine_temperature", rsp_beat.fine_temperature,
                               e.fine_temperature);
            if (rsp_beat.pressure_pa !== e.pressure_pa)
               report_mismatch("pressure_pa", rsp_beat.pressure_pa, e.pressure_pa);
            if (rsp_beat.humidity_q10 !== e.humidity_q10)
               report_mismatch("humidity_q10", 32'(rsp_beat.humidity_q10),
                               32'(e.humidity_q10));
         end
      end
   end

   task automatic send_reading(thp_pkg::req_type r);
      @(negedge clock);
      req_start <= 1'b1;
      req_beat <= r;
      do @(posedge clock); while (req_busy);
      pending_readings.push_back(compensate(r, cal_shadow));
      beats_sent++;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_start <= 1'b0;
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_start <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_cal(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         thp_pkg::REG_TCAL:    cal_shadow.tcal = value[47:0];
         thp_pkg::REG_PCAL_LO: cal_shadow.pcal_lo = value;
         thp_pkg::REG_PCAL_HI: cal_shadow.pcal_hi = value;
         thp_pkg::REG_PCAL_TP: cal_shadow.pcal_top = value[15:0];
         thp_pkg::REG_HCAL:    cal_shadow.hcal = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_cal(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                           logic [15:0] pt, logic [63:0] hc);
      drain();
      write_cal(thp_pkg::REG_TCAL, {16'd0, t});
      write_cal(thp_pkg::REG_PCAL_LO, pl);
      write_cal(thp_pkg::REG_PCAL_HI, ph);
      write_cal(thp_pkg::REG_PCAL_TP, {48'd0, pt});
      write_cal(thp_pkg::REG_HCAL, hc);
   endtask

   function automatic thp_pkg::req_type mk(int t, int p, int h);
      thp_pkg::req_type r;
      r.raw_temperature = 20'(t);
      r.raw_pressure = 20'(p);
      r.raw_humidity = 16'(h);
      return r;
   endfunction

   function automatic thp_pkg::req_type rand_reading(bit plausible);
      if (plausible)
         return mk($urandom_range(600000, 400000), $urandom_range(500000, 200000),
                   $urandom_range(40000, 15000));
      return mk(int'($urandom), int'($urandom), int'($urandom));
   endfunction

   // zero calibration: divisor is zero so pressure reads zero
   task automatic test_reset_calibration;
      send_reading(mk(0, 0, 0));
      send_reading(mk(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
      send_reading(mk(519888, 415148, 30000));
   endtask

   task automatic test_typical_extremes;
      load_cal(TCAL_TYP, PLO_TYP, PHI_TYP, PTOP_TYP, HCAL_TYP);
      send_reading(mk(519888, 415148, 30000));
      send_reading(mk(0, 0, 0));
      send_reading(mk(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
      send_reading(mk(0, 20'hFFFFF, 0));
      send_reading(mk(20'hFFFFF, 0, 16'hFFFF));
      send_reading(mk(519888, 0, 16'hFFFF));
      send_reading(mk(519888, 20'hFFFFF, 0));
      send_reading(mk(20'h55555, 20'hAAAAA, 16'h5555));
      send_reading(mk(20'hAAAAA, 20'h55555, 16'hAAAA));
   endtask

   task automatic test_calibration_extremes;
      load_cal('1, '1, '1, '1, '1);
      send_reading(mk(519888, 415148, 30000));
      send_reading(mk(20'hFFFFF, 0, 16'hFFFF));
      load_cal({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
               {4{16'h8000}}, 16'h8000, 64'h8080_0800_FF80_00FF);
      send_reading(mk(519888, 415148, 30000));
      send_reading(mk(0, 20'hFFFFF, 0));
      load_cal({16'h7FFF, 16'h7FFF, 16'd0}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF,
               64'h7F7F_F7FF_007F_FF00);
      send_reading(mk(519888, 415148, 30000));
      send_reading(mk(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
   endtask

   task automatic test_random_phase(int pct, int blocks);
      idle_pct = pct;
      for (int k = 0; k < blocks; k++) begin
         if ($urandom_range(2) == 0)
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
         else
            load_cal(TCAL_TYP ^ 48'($urandom_range(255)), PLO_TYP ^ 64'($urandom_range(63)),
                     PHI_TYP ^ 64'($urandom_range(63)), PTOP_TYP ^ 16'($urandom_range(63)),
                     HCAL_TYP ^ {8'($urandom_range(15)), 48'd0, 8'($urandom_range(255))});
         repeat (60) send_reading(rand_reading($urandom_range(3) != 0));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_calibration();
      test_typical_extremes();
      test_calibration_extremes();
      test_random_phase(38, 8);
      test_random_phase(48, 8);
      test_random_phase(0, 8);
      drain();
      $display("covered %0d readings (%0d checked): zero, typical, extreme and random",
               beats_sent, beats_checked);
      $display("calibration sets, with request gaps in three densities");
      if (mismatch_count == 0) begin
         $display("thp_sensor_compensation_core_test: PASS");
      end else begin
         $display("thp_sensor_compensation_core_test: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("thp_sensor_compensation_core_test: FAIL");
      $finish;
   end

endmodule
